// File: rtl/ssra_pkg.sv
// Shared constants, types and helpers of the swap slot allocator.
package ssra_pkg;

  localparam int SLOT_COUNT = 16384;
  localparam int GROUP_SIZE = 2048;
  localparam int NUM_GROUPS = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int ADDR_W    = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int FREE_W    = $clog2(GROUP_SIZE + 1);
  localparam int GRP_SHIFT = $clog2(GROUP_SIZE);
  localparam int GIDX_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GC_W      = $clog2(NUM_GROUPS + 1);
  localparam int POS_W     = ((CNT_W > GC_W + GRP_SHIFT) ? CNT_W : GC_W + GRP_SHIFT) + 1;

  // fixed field widths
  localparam int KIND_W      = 3;
  localparam int OFF_W       = 17;
  localparam int BASE_W      = 16;
  localparam int USABLE_W    = 15;
  localparam int USED_W      = 15;
  localparam int STATUS_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = OFF_W + 1 + BYTE_W + USED_W;
  localparam int OUT_TDATA_W = 48;

  localparam logic [6:0]        COUNT_MAX  = 7'h7f;
  localparam logic [BYTE_W-1:0] CACHE_MARK = 8'h80;
  localparam logic [USED_W-1:0] USED_MAX   = '1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_USABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 3'd0,
    KIND_PUT   = 3'd1,
    KIND_INC   = 3'd2,
    KIND_UNSET = 3'd3,
    KIND_FREE  = 3'd4,
    KIND_READ  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_GROUP,
    ST_SCAN,
    ST_GRANT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic rd_issue;
    logic commit_single;
    logic grp_next;
    logic grp_enter;
    logic scan_issue;
    logic commit_grant;
    logic commit_fail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic refill;
    logic clr_done;
    logic grp_none;
    logic grp_empty;
    logic scan_hit;
    logic scan_more;
  } dp_sts_t;

  function automatic logic [POS_W-1:0] grp_start(input logic [GC_W-1:0] g);
    return POS_W'(g) << GRP_SHIFT;
  endfunction

  // slots in group g for a given usable count
  function automatic logic [FREE_W-1:0] grp_size(input logic [CNT_W-1:0] usable,
                                                 input logic [GC_W-1:0]  g);
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] left;
    start = grp_start(g);
    left  = POS_W'(usable) - start;
    if (start >= POS_W'(usable)) begin
      return '0;
    end
    if (left < POS_W'(GROUP_SIZE)) begin
      return FREE_W'(left);
    end
    return FREE_W'(GROUP_SIZE);
  endfunction

endpackage

// File: rtl/ssra_datapath.sv
// Datapath: slot map memory, group free counts, usage count, config and result registers.
module ssra_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssra_pkg::ctrl_cmd_t              cmd,
  output ssra_pkg::dp_sts_t                sts,
  input  logic                             cfg_wr,
  input  logic [ssra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ssra_pkg::KIND_W-1:0]      in_kind,
  input  logic [ssra_pkg::OFF_W-1:0]       in_offset,
  output logic [ssra_pkg::STATUS_W-1:0]    out_status,
  output logic [ssra_pkg::OFF_W-1:0]       out_granted,
  output logic                             out_zero,
  output logic [ssra_pkg::BYTE_W-1:0]      out_byte,
  output logic [ssra_pkg::USED_W-1:0]      out_used
);

  // config and counters
  logic [ssra_pkg::CNT_W-1:0]   usable_r;
  logic [ssra_pkg::BASE_W-1:0]  base_r;
  logic [ssra_pkg::USED_W-1:0]  used_r;
  logic [ssra_pkg::FREE_W-1:0]  free_r [ssra_pkg::NUM_GROUPS];
  logic [ssra_pkg::CNT_W-1:0]   clr_addr_r;

  // current item
  ssra_pkg::kind_t              kind_r;
  logic [ssra_pkg::ADDR_W-1:0]  idx_r;
  logic                         oor_r;

  // scan
  logic [ssra_pkg::GC_W-1:0]    g_r;
  logic [ssra_pkg::CNT_W-1:0]   rd_addr_r;
  logic [ssra_pkg::ADDR_W-1:0]  chk_addr_r;
  logic                         chk_v_r;

  // slot map
  logic [ssra_pkg::BYTE_W-1:0]  mem [ssra_pkg::SLOT_COUNT];
  logic [ssra_pkg::BYTE_W-1:0]  rdata_r;

  // result register
  logic [ssra_pkg::STATUS_W-1:0] out_status_r;
  logic [ssra_pkg::OFF_W-1:0]    out_granted_r;
  logic                          out_zero_r;
  logic [ssra_pkg::BYTE_W-1:0]   out_byte_r;
  logic [ssra_pkg::USED_W-1:0]   out_used_r;

  logic                          refill;
  logic [ssra_pkg::USABLE_W-1:0] cfg_usable;
  logic [ssra_pkg::CNT_W-1:0]    usable_new;
  logic [ssra_pkg::OFF_W:0]      diff;
  logic [ssra_pkg::GIDX_W-1:0]   g_idx;
  logic [ssra_pkg::GIDX_W-1:0]   sg;
  logic [ssra_pkg::POS_W-1:0]    start;
  logic [ssra_pkg::POS_W-1:0]    grp_end;

  logic [ssra_pkg::BYTE_W-1:0]   b;
  logic [6:0]                    cnt;
  logic [ssra_pkg::BYTE_W-1:0]   new_b;
  logic [ssra_pkg::STATUS_W-1:0] st_s;
  logic                          zero_s;
  logic [ssra_pkg::USED_W-1:0]   used_s;
  logic                          free_inc;
  logic                          valid_kind;
  logic                          single_wr;

  logic                          we;
  logic [ssra_pkg::ADDR_W-1:0]   waddr;
  logic [ssra_pkg::BYTE_W-1:0]   wdata;
  logic                          re;
  logic [ssra_pkg::ADDR_W-1:0]   raddr;

  assign refill     = cfg_wr && (cfg_index == ssra_pkg::REG_USABLE);
  assign cfg_usable = cfg_data[ssra_pkg::USABLE_W-1:0];
  assign usable_new = (32'(cfg_usable) > ssra_pkg::SLOT_COUNT) ?
                      ssra_pkg::CNT_W'(ssra_pkg::SLOT_COUNT) : ssra_pkg::CNT_W'(cfg_usable);

  // range check of the incoming offset against base and usable count
  assign diff = {1'b0, in_offset} - (ssra_pkg::OFF_W + 1)'(base_r);

  assign g_idx   = ssra_pkg::GIDX_W'(g_r);
  assign sg      = ssra_pkg::GIDX_W'(idx_r >> ssra_pkg::GRP_SHIFT);
  assign start   = ssra_pkg::grp_start(g_r);
  assign grp_end = start + ssra_pkg::POS_W'(ssra_pkg::grp_size(usable_r, g_r));

  assign sts.refill    = refill;
  assign sts.clr_done  = clr_addr_r >= usable_r;
  assign sts.grp_none  = (g_r >= ssra_pkg::GC_W'(ssra_pkg::NUM_GROUPS)) ||
                         (start >= ssra_pkg::POS_W'(usable_r));
  assign sts.grp_empty = free_r[g_idx] == '0;
  assign sts.scan_hit  = chk_v_r && (rdata_r == '0);
  assign sts.scan_more = ssra_pkg::POS_W'(rd_addr_r) < grp_end;

  // read-modify-write of one slot byte
  always_comb begin
    b        = rdata_r;
    cnt      = rdata_r[6:0];
    new_b    = rdata_r;
    st_s     = ssra_pkg::STATUS_OK;
    zero_s   = 1'b0;
    used_s   = used_r;
    free_inc = 1'b0;
    valid_kind = 1'b1;
    unique case (kind_r)
      ssra_pkg::KIND_PUT: begin
        if (cnt != '0) begin
          new_b = b - 8'd1;
        end
        zero_s = cnt <= 7'd1;
      end
      ssra_pkg::KIND_INC: begin
        if (cnt == ssra_pkg::COUNT_MAX) begin
          st_s = ssra_pkg::STATUS_REFUSED;
        end else begin
          new_b = b + 8'd1;
        end
      end
      ssra_pkg::KIND_UNSET: begin
        if (cnt == '0 && used_r != '0) begin
          used_s = used_r - 1'b1;
        end
        new_b = {1'b0, cnt};
      end
      ssra_pkg::KIND_FREE: begin
        if (cnt != '0) begin
          st_s = ssra_pkg::STATUS_REFUSED;
        end else begin
          if (b != '0 &&
              free_r[sg] < ssra_pkg::grp_size(usable_r, ssra_pkg::GC_W'(sg))) begin
            free_inc = 1'b1;
          end
          new_b = '0;
        end
      end
      ssra_pkg::KIND_READ: begin
      end
      default: begin
        // allocate never lands here; unknown kinds touch nothing
        valid_kind = 1'b0;
      end
    endcase
    if (!valid_kind) begin
      st_s   = ssra_pkg::STATUS_OK;
      zero_s = 1'b0;
      new_b  = '0;
    end else if (oor_r) begin
      st_s     = ssra_pkg::STATUS_RANGE;
      zero_s   = 1'b0;
      new_b    = '0;
      used_s   = used_r;
      free_inc = 1'b0;
    end
  end

  assign single_wr = valid_kind && !oor_r;

  // memory port muxing
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_r[ssra_pkg::ADDR_W-1:0];
    wdata = '0;
    if (cmd.clr_step && !refill) begin
      we = 1'b1;
    end else if (cmd.commit_single && single_wr) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = new_b;
    end else if (cmd.commit_grant) begin
      we    = 1'b1;
      waddr = chk_addr_r;
      wdata = ssra_pkg::CACHE_MARK;
    end
    re    = cmd.rd_issue || cmd.scan_issue;
    raddr = cmd.rd_issue ? idx_r : rd_addr_r[ssra_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // config, counters and clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r   <= ssra_pkg::CNT_W'(ssra_pkg::SLOT_COUNT);
      base_r     <= '0;
      used_r     <= '0;
      clr_addr_r <= '0;
      for (int g = 0; g < ssra_pkg::NUM_GROUPS; g++) begin
        free_r[g] <= ssra_pkg::grp_size(ssra_pkg::CNT_W'(ssra_pkg::SLOT_COUNT),
                                        ssra_pkg::GC_W'(g));
      end
    end else begin
      if (cfg_wr && cfg_index == ssra_pkg::REG_BASE) begin
        base_r <= cfg_data[ssra_pkg::BASE_W-1:0];
      end
      if (refill) begin
        usable_r   <= usable_new;
        used_r     <= '0;
        clr_addr_r <= '0;
        for (int g = 0; g < ssra_pkg::NUM_GROUPS; g++) begin
          free_r[g] <= ssra_pkg::grp_size(usable_new, ssra_pkg::GC_W'(g));
        end
      end else begin
        if (cmd.clr_step) begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
        if (cmd.commit_grant) begin
          free_r[g_idx] <= free_r[g_idx] - 1'b1;
          if (used_r != ssra_pkg::USED_MAX) begin
            used_r <= used_r + 1'b1;
          end
        end
        if (cmd.commit_single) begin
          used_r <= used_s;
          if (free_inc) begin
            free_r[sg] <= free_r[sg] + 1'b1;
          end
        end
      end
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
      g_r     <= '0;
    end else begin
      if (cmd.load_item) begin
        g_r <= '0;
      end else if (cmd.grp_next) begin
        g_r <= g_r + 1'b1;
      end
      if (cmd.grp_enter || cmd.grp_next) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan_issue) begin
        chk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= ssra_pkg::kind_t'(in_kind);
      idx_r  <= diff[ssra_pkg::ADDR_W-1:0];
      oor_r  <= diff[ssra_pkg::OFF_W] ||
                (diff[ssra_pkg::OFF_W-1:0] >= ssra_pkg::OFF_W'(usable_r));
    end
    if (cmd.grp_enter) begin
      rd_addr_r <= ssra_pkg::CNT_W'(start);
    end else if (cmd.scan_issue) begin
      rd_addr_r  <= rd_addr_r + 1'b1;
      chk_addr_r <= rd_addr_r[ssra_pkg::ADDR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit_single) begin
      out_status_r  <= st_s;
      out_granted_r <= '0;
      out_zero_r    <= zero_s;
      out_byte_r    <= new_b;
      out_used_r    <= used_s;
    end else if (cmd.commit_grant) begin
      out_status_r  <= ssra_pkg::STATUS_OK;
      out_granted_r <= ssra_pkg::OFF_W'(chk_addr_r) + ssra_pkg::OFF_W'(base_r);
      out_zero_r    <= 1'b0;
      out_byte_r    <= ssra_pkg::CACHE_MARK;
      out_used_r    <= (used_r != ssra_pkg::USED_MAX) ? used_r + 1'b1 : used_r;
    end else if (cmd.commit_fail) begin
      out_status_r  <= ssra_pkg::STATUS_NO_SLOT;
      out_granted_r <= '0;
      out_zero_r    <= 1'b0;
      out_byte_r    <= '0;
      out_used_r    <= used_r;
    end
  end

  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;
  assign out_zero    = out_zero_r;
  assign out_byte    = out_byte_r;
  assign out_used    = out_used_r;

endmodule

// File: rtl/ssra_ctrl.sv
// Controller: sequences clearing, single-slot updates and the allocate scan.
module ssra_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [ssra_pkg::KIND_W-1:0] in_kind,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  ssra_pkg::dp_sts_t           sts,
  output ssra_pkg::ctrl_cmd_t         cmd
);

  ssra_pkg::state_t state_r;
  ssra_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_free;
  logic             commit;

  assign out_free   = !out_valid_r || out_tready;
  assign commit     = cmd.commit_single || cmd.commit_grant || cmd.commit_fail;
  assign in_tready  = state_r == ssra_pkg::ST_IDLE;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssra_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ssra_pkg::ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ssra_pkg::ST_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      ssra_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt = (in_kind == ssra_pkg::KIND_ALLOC) ? ssra_pkg::ST_GROUP
                                                        : ssra_pkg::ST_READ;
        end
      end
      ssra_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ssra_pkg::ST_MODIFY;
      end
      ssra_pkg::ST_MODIFY: begin
        if (out_free) begin
          cmd.commit_single = 1'b1;
          state_nxt         = ssra_pkg::ST_IDLE;
        end
      end
      ssra_pkg::ST_GROUP: begin
        priority if (sts.grp_none) begin
          state_nxt = ssra_pkg::ST_FAIL;
        end else if (sts.grp_empty) begin
          cmd.grp_next = 1'b1;
        end else begin
          cmd.grp_enter = 1'b1;
          state_nxt     = ssra_pkg::ST_SCAN;
        end
      end
      ssra_pkg::ST_SCAN: begin
        // compare of the byte read last cycle overlaps the next read
        priority if (sts.scan_hit) begin
          state_nxt = ssra_pkg::ST_GRANT;
        end else if (sts.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          cmd.grp_next = 1'b1;
          state_nxt    = ssra_pkg::ST_GROUP;
        end
      end
      ssra_pkg::ST_GRANT: begin
        if (out_free) begin
          cmd.commit_grant = 1'b1;
          state_nxt        = ssra_pkg::ST_IDLE;
        end
      end
      ssra_pkg::ST_FAIL: begin
        if (out_free) begin
          cmd.commit_fail = 1'b1;
          state_nxt       = ssra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssra_pkg::ST_CLEAR;
      end
    endcase
    // new usable count restarts the clearing pass
    if (sts.refill) begin
      state_nxt = ssra_pkg::ST_CLEAR;
    end
  end

endmodule

// File: rtl/swap_slot_refcount_allocator.sv
// Top level of the swap slot allocator with per-slot reference counts.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------------
//  in_      | in  | in_tvalid / in_tready  | tuser kind, tdata slot_offset
//  out_     | out | out_tvalid / out_tready| tuser status, tdata granted..used_slots
//  cfg_     | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Put, increment, unset, final put and read: the map byte is read in ST_READ and the result
// register is loaded in ST_MODIFY; the next item is taken in ST_IDLE after that.
// Allocate: empty groups are skipped one by one, a non-empty group is scanned one map byte
// read at a time (one read port), then the grant is committed (or the no-slot result).
// After reset and after each usable_slots write a clearing pass over the usable_slots map bytes
// runs; no input transfer is taken during it, config writes are.
// A result waiting on out_tready holds only the final commit; the next item is taken
// as soon as the result register has been loaded.
module swap_slot_refcount_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssra_pkg::IN_TDATA_W-1:0]   in_tdata,   // [16:0] slot_offset
  input  logic [ssra_pkg::KIND_W-1:0]       in_tuser,   // [2:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [16:0] granted_offset, [17] count_is_zero, [25:18] map_byte, [40:26] used_slots
  output logic [ssra_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [ssra_pkg::STATUS_W-1:0]     out_tuser,  // [1:0] status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssra_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ssra_pkg::ctrl_cmd_t             cmd;
  ssra_pkg::dp_sts_t               sts;
  logic                            cfg_wr;
  logic [ssra_pkg::OFF_W-1:0]      granted;
  logic                            zero;
  logic [ssra_pkg::BYTE_W-1:0]     map_byte;
  logic [ssra_pkg::USED_W-1:0]     used;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  ssra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssra_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr      (cfg_wr),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_kind     (in_tuser),
    .in_offset   (in_tdata[ssra_pkg::OFF_W-1:0]),
    .out_status  (out_tuser),
    .out_granted (granted),
    .out_zero    (zero),
    .out_byte    (map_byte),
    .out_used    (used)
  );

  assign out_tdata = {{(ssra_pkg::OUT_TDATA_W - ssra_pkg::OUT_FIELD_W){1'b0}},
                      used, map_byte, zero, granted};

endmodule

// File: rtl/ssra_checker.sv
// Port-level checker for the swap slot allocator, bound to the top level.
module ssra_port_assert (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ssra_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ssra_pkg::STATUS_W-1:0]    out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the map is being cleared right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // a failed allocation grants nothing
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ssra_pkg::STATUS_NO_SLOT |->
      out_tdata[16:0] == '0 && out_tdata[25:18] == '0)
    else $error("no-slot result carries a slot");

endmodule

bind swap_slot_refcount_allocator ssra_port_assert u_ssra_checker (.*);

// File: bench/ssra_checker.sv
// Checker for the swap slot allocator: mirrors slot map state and compares every reply.
`timescale 1ns / 1ps
module ssra_checker
  import ssra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [16:0] slot_offset
  input  logic [KIND_W-1:0]      in_tuser,   // [2:0] kind
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [16:0] granted_offset, [17] count_is_zero, [25:18] map_byte, [40:26] used_slots
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]    out_tuser,  // [1:0] status
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    granted;
    logic                now_zero;
    logic [BYTE_W-1:0]   map_byte;
    logic [USED_W-1:0]   used;
  } slot_reply_t;

  slot_reply_t       awaited_replies[$];
  logic [BYTE_W-1:0] slot_bytes [SLOT_COUNT];
  int unsigned       grp_free [NUM_GROUPS];
  int unsigned       used_cnt;
  int unsigned       usable_cnt;
  int unsigned       base_off;

  // slots that fall in group g under the current usable count
  function automatic int unsigned group_span(input int unsigned g);
    int unsigned first;
    first = g * GROUP_SIZE;
    if (first >= usable_cnt) begin
      return 0;
    end
    return (usable_cnt - first < GROUP_SIZE) ? usable_cnt - first : GROUP_SIZE;
  endfunction

  function automatic void wipe_map();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_bytes[i] = '0;
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_free[g] = group_span(g);
    end
    used_cnt = 0;
  endfunction

  function automatic slot_reply_t slot_op_outcome(input logic [KIND_W-1:0] k,
                                                  input logic [OFF_W-1:0]  off);
    slot_reply_t       r;
    int unsigned       idx;
    int unsigned       g;
    int unsigned       first;
    int unsigned       stop;
    logic [BYTE_W-1:0] b;
    logic [6:0]        cnt;
    bit                found;
    r = '0;
    if (k == KIND_ALLOC) begin
      found = 1'b0;
      // groups with a zero free count are skipped even if a zero byte sits there
      for (g = 0; g < NUM_GROUPS && !found; g++) begin
        first = g * GROUP_SIZE;
        stop  = first + group_span(g);
        if (grp_free[g] != 0) begin
          for (idx = first; idx < stop && !found; idx++) begin
            if (slot_bytes[idx] == '0) begin
              slot_bytes[idx] = CACHE_MARK;
              grp_free[g]--;
              if (used_cnt < USED_MAX) begin
                used_cnt++;
              end
              r.granted  = OFF_W'(idx + base_off);
              r.map_byte = CACHE_MARK;
              found      = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        r.status = STATUS_NO_SLOT;
      end
    end else if (k <= KIND_READ) begin
      if (off < base_off || off - base_off >= usable_cnt) begin
        r.status = STATUS_RANGE;
      end else begin
        idx = off - base_off;
        b   = slot_bytes[idx];
        cnt = b[6:0];
        case (k)
          KIND_PUT: begin
            if (cnt != 0) begin
              b   = b - 1'b1;
              cnt = cnt - 1'b1;
            end
            r.now_zero = (cnt == 0);
          end
          KIND_INC: begin
            if (cnt == COUNT_MAX) begin
              r.status = STATUS_REFUSED;
            end else begin
              b = b + 1'b1;
            end
          end
          KIND_UNSET: begin
            if (cnt == 0 && used_cnt > 0) begin
              used_cnt--;
            end
            b = {1'b0, cnt};
          end
          KIND_FREE: begin
            if (cnt != 0) begin
              r.status = STATUS_REFUSED;
            end else begin
              g = idx / GROUP_SIZE;
              if (b != 0 && grp_free[g] < group_span(g)) begin
                grp_free[g]++;
              end
              b = '0;
            end
          end
          default: ;
        endcase
        slot_bytes[idx] = b;
        r.map_byte      = b;
      end
    end
    r.used = USED_W'(used_cnt);
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    slot_reply_t want;
    if (!rst_n) begin
      usable_cnt = SLOT_COUNT;
      base_off   = 0;
      wipe_map();
      awaited_replies.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_replies.size() == 0) begin
          report("reply with nothing pending", out_tuser, 0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_tuser !== want.status) begin
            report("status", out_tuser, want.status);
          end
          if (out_tdata[16:0] !== want.granted) begin
            report("granted_offset", out_tdata[16:0], want.granted);
          end
          if (out_tdata[17] !== want.now_zero) begin
            report("count_is_zero", out_tdata[17], want.now_zero);
          end
          if (out_tdata[25:18] !== want.map_byte) begin
            report("map_byte", out_tdata[25:18], want.map_byte);
          end
          if (out_tdata[40:26] !== want.used) begin
            report("used_slots", out_tdata[40:26], want.used);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_replies.push_back(slot_op_outcome(in_tuser, in_tdata[OFF_W-1:0]));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_USABLE) begin
          usable_cnt = (cfg_data[USABLE_W-1:0] > SLOT_COUNT) ?
                       SLOT_COUNT : cfg_data[USABLE_W-1:0];
          wipe_map();
        end else begin
          base_off = cfg_data;
        end
      end
    end
    pending = awaited_replies.size();
  end

endmodule

// File: bench/tb_swap_slot_refcount_allocator.sv
// Testbench top for the swap slot allocator: reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_swap_slot_refcount_allocator;
  import ssra_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     pending;

  bit                     no_idle;
  int unsigned            cur_usable;
  int unsigned            cur_base;

  swap_slot_refcount_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ssra_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: a fresh stall length after every result transfer
  initial begin : result_pacing
    int w;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      w = no_idle ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] k, input logic [OFF_W-1:0] off);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= IN_TDATA_W'(off);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the input side until every reply is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_USABLE) begin
      cur_usable = (value[USABLE_W-1:0] > SLOT_COUNT) ? SLOT_COUNT : value[USABLE_W-1:0];
    end else begin
      cur_base = value;
    end
  endtask

  // mostly low slot indices so ops land on slots that allocate hands out
  function automatic logic [OFF_W-1:0] pick_offset();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (cur_usable == 0 || r < 12) begin
      case ($urandom_range(0, 3))
        0: return (cur_base > 0) ? OFF_W'(cur_base - 1) : OFF_W'(cur_base + cur_usable);
        1: return OFF_W'(cur_base + cur_usable);
        2: return OFF_W'(cur_base + cur_usable + $urandom_range(0, 63));
        default: return OFF_W'($urandom);
      endcase
    end
    span = (cur_usable < 48) ? cur_usable : 48;
    if (r < 82) begin
      return OFF_W'(cur_base + $urandom_range(0, span - 1));
    end
    return OFF_W'(cur_base + $urandom_range(0, cur_usable - 1));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input bit inc_heavy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (inc_heavy) begin
      if (r < 85) return KIND_INC;
      if (r < 90) return KIND_PUT;
      if (r < 93) return KIND_READ;
      if (r < 95) return KIND_ALLOC;
      if (r < 97) return KIND_FREE;
      if (r < 99) return KIND_UNSET;
      return KIND_SPARE_6;
    end
    if (r < 26) return KIND_ALLOC;
    if (r < 40) return KIND_PUT;
    if (r < 58) return KIND_INC;
    if (r < 70) return KIND_UNSET;
    if (r < 84) return KIND_FREE;
    if (r < 97) return KIND_READ;
    if (r < 99) return KIND_SPARE_6;
    return KIND_SPARE_7;
  endfunction

  task automatic run_phase(input bit set_usable, input logic [CFG_DATA_W-1:0] usable_word,
                           input logic [CFG_DATA_W-1:0] base, input int items,
                           input bit inc_heavy);
    drain();
    if (set_usable) begin
      write_reg(REG_USABLE, usable_word);
    end
    write_reg(REG_BASE, base);
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 4) == 0);
      end
      if (n == items / 2) begin
        drain();
      end
      send_op(pick_kind(inc_heavy), pick_offset());
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    no_idle    = 1'b0;
    cur_usable = SLOT_COUNT;
    cur_base   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default config, base 0
    send_op(KIND_ALLOC, 17'd0);
    send_op(KIND_ALLOC, 17'h1ffff);
    send_op(KIND_READ, 17'd0);
    send_op(KIND_INC, 17'd0);
    send_op(KIND_INC, 17'd0);
    send_op(KIND_PUT, 17'd0);
    send_op(KIND_PUT, 17'd0);
    send_op(KIND_PUT, 17'd0);        // put with count already zero
    send_op(KIND_FREE, 17'd1);       // frees a cache-only slot
    send_op(KIND_ALLOC, 17'd0);
    send_op(KIND_INC, 17'd1);
    send_op(KIND_FREE, 17'd1);       // still referenced
    send_op(KIND_UNSET, 17'd1);
    send_op(KIND_UNSET, 17'd0);
    send_op(KIND_UNSET, 17'd9);      // slot never allocated
    send_op(KIND_INC, 17'd3);
    send_op(KIND_FREE, 17'd3);
    send_op(KIND_PUT, 17'd3);
    send_op(KIND_FREE, 17'd3);       // zero byte, group count untouched
    send_op(KIND_READ, 17'd16383);
    send_op(KIND_READ, 17'd16384);
    send_op(KIND_INC, 17'h1ffff);
    send_op(KIND_SPARE_6, 17'd0);
    send_op(KIND_SPARE_7, 17'h1ffff);

    run_phase(1'b0, 16'd0,     16'd0,     120, 1'b0);
    run_phase(1'b1, 16'd1,     16'hffff,  260, 1'b1);
    run_phase(1'b1, 16'd0,     16'd100,   40,  1'b0);
    run_phase(1'b1, 16'h7fff,  16'd49000, 120, 1'b0);
    run_phase(1'b1, 16'h8005,  16'd0,     200, 1'b0);
    run_phase(1'b1, 16'd37,    16'd3,     200, 1'b0);
    run_phase(1'b1, 16'd2049,  16'd7,     150, 1'b0);
    run_phase(1'b0, 16'd0,     16'd65000, 100, 1'b0);
    run_phase(1'b1, 16'd16,    16'd1,     200, 1'b0);
    run_phase(1'b1, 16'd2,     16'd0,     150, 1'b1);
    run_phase(1'b1, 16'd300,   16'd20000, 140, 1'b0);

    drain();
    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
